@@ hdl/sds_pkg.sv @@
// Package for the steepest-descent solver: sizes, codes and fixed-point helpers.
// Used by every module under hdl; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package sds_pkg;
    localparam int Dim = 16;
    localparam int IdxW = 4;

    localparam logic [1:0] KIND_MAT = 2'd0;
    localparam logic [1:0] KIND_RHS = 2'd1;
    localparam logic [1:0] KIND_SOL = 2'd2;
    localparam logic [1:0] KIND_RUN = 2'd3;

    localparam logic [1:0] ST_CONV = 2'd0;
    localparam logic [1:0] ST_LIMIT = 2'd1;
    localparam logic [1:0] ST_SING = 2'd2;

    localparam logic CFG_TOL = 1'b0;
    localparam logic CFG_MAXIT = 1'b1;

    // Control to each cell of the row
    typedef struct packed {
        logic       clr;   // clear accumulator
        logic       mac;   // accumulate product of its operands
    } t_cell_ctl;

    // saturating signed 64-bit add
    function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s;
    endfunction

    // saturate 64-bit to 32-bit signed
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -64'sh80000000) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Q32.32 to Q16.16: floor then saturate
    function automatic logic signed [31:0] q_from_wide(input logic signed [63:0] v);
        logic signed [63:0] f;
        f = v >>> 16;
        return sat32(f);
    endfunction
endpackage
`default_nettype wire

@@ hdl/sds_cell.sv @@
// One cell of the multiply-accumulate row: a 32x32 product register and a
// saturating 64-bit accumulator. Depends on sds_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sds_cell (
    input  wire logic                  i_clk,
    input  wire sds_pkg::t_cell_ctl    i_ctl,
    input  wire logic signed [31:0]    i_a,
    input  wire logic signed [31:0]    i_b,
    input  wire logic signed [63:0]    i_chain,
    output logic signed [63:0]         o_acc,
    output logic signed [63:0]         o_chain
);
    import sds_pkg::*;

    logic signed [63:0] r_prod;
    logic               r_mac;
    logic signed [63:0] r_acc;
    logic signed [63:0] r_chain;

    // multiply stage, then accumulate stage
    always_ff @(posedge i_clk) begin
        r_prod  <= 64'(i_a) * 64'(i_b);
        r_mac   <= i_ctl.mac;
        r_chain <= i_chain;
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_mac) begin
            r_acc <= add_sat64(r_acc, r_prod);
        end
    end

    assign o_acc   = r_acc;
    assign o_chain = r_chain;
endmodule
`default_nettype wire

@@ hdl/sds_divider.sv @@
// Restoring divider: floor(2^16*n/d) saturated to Q16.16 max, one bit a cycle.
// Depends on sds_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sds_divider (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [63:0]   i_num,
    input  wire logic [63:0]   i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);
    import sds_pkg::*;

    // dividend is n * 2^16 (80 bits); 80 quotient bits produced
    logic [79:0] r_num;
    logic [64:0] r_rem;
    logic [79:0] r_q;
    logic [63:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [64:0] w_sh;
    logic        w_ge;

    assign w_sh = {r_rem[63:0], r_num[79]};
    assign w_ge = w_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_num  <= {i_num, 16'd0};
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= 7'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[78:0], 1'b0};
                r_rem <= w_ge ? w_sh - {1'b0, r_den} : w_sh;
                r_q   <= {r_q[78:0], w_ge};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd79) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = (r_q[79:31] != '0) ? 32'sh7FFFFFFF : r_q[31:0];
endmodule
`default_nettype wire

@@ hdl/steepest_descent_solver.sv @@
// Top level of the steepest-descent solver: stores, cell row, sequencer.
// Depends on sds_pkg, sds_cell and sds_divider.
`timescale 1ns / 1ps
`default_nettype none
// Load words are taken one per cycle and produce nothing. A start word runs
// the solve and then returns 16 solution words. Each pass uses a row of 16
// multiply-accumulate cells, one per matrix row, fed one column per cycle
// from the matrix memory. A*x and A*r each stream all columns and then drain
// the pipeline, the two dot products ride the same row in column 0, r is
// formed in its own state, the scalar alpha comes from a one-bit-per-cycle
// divider and then x is updated, and each pass begins with the limit check.
// Delivery of the 16 words waits while the receiver stalls. The input stalls
// while a solve runs or its words are being delivered.
module steepest_descent_solver (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_kind,
    input  wire logic [3:0]         i_row,
    input  wire logic [3:0]         i_col,
    input  wire logic signed [31:0] i_value,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [62:0]        i_cfg_data,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [3:0]              o_index,
    output logic signed [31:0]      o_solution,
    output logic [15:0]             o_iterations,
    output logic [1:0]              o_status,
    output logic                    o_last
);
    import sds_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_AX, S_AXW, S_RES, S_RR, S_RRW, S_AR, S_ARW,
        S_DEN, S_DENW, S_DIV, S_UPD, S_UPDW, S_OUT
    } t_state;

    // operand selection of the cell row
    localparam logic [1:0] MODE_AX  = 2'd0;
    localparam logic [1:0] MODE_AR  = 2'd1;
    localparam logic [1:0] MODE_RR  = 2'd2;
    localparam logic [1:0] MODE_DEN = 2'd3;

    t_state r_state;
    logic [62:0] r_tol;
    logic [15:0] r_maxit;
    logic [15:0] r_iters;
    logic [1:0]  r_status;

    // stores
    logic signed [31:0] r_mat [Dim][Dim];   // one bank per row, read by column
    logic signed [31:0] r_rhs [Dim];
    logic signed [31:0] r_x   [Dim];
    logic signed [31:0] r_r   [Dim];
    logic signed [31:0] r_p   [Dim];

    logic [IdxW:0]  r_cnt;
    logic [IdxW-1:0] w_j;
    logic signed [63:0] r_rr;
    logic signed [63:0] r_ss;
    logic signed [31:0] r_alpha;

    // cell row
    t_cell_ctl r_ctl;
    logic signed [31:0] w_a [Dim];
    logic signed [31:0] w_b [Dim];
    logic signed [63:0] w_acc [Dim];
    logic signed [63:0] w_ch [Dim+1];
    logic signed [31:0] r_colv [Dim];
    logic signed [31:0] r_vec;
    logic [1:0]   r_mode;   // 0 matvec x, 1 matvec r, 2 dot r.r, 3 dot r.p

    logic         w_div_start;
    logic         w_div_done;
    logic signed [31:0] w_quot;
    logic signed [31:0] w_s;
    logic signed [63:0] w_s2;

    // update pipeline: step formed in one cycle, applied in the next
    logic signed [31:0] r_s;
    logic [IdxW-1:0]    r_s_idx;
    logic               r_s_vld;

    assign w_j = r_cnt[IdxW-1:0];
    assign w_ch[0] = '0;

    genvar g;
    generate
        for (g = 0; g < Dim; g++) begin : g_cell
            assign w_a[g] = (r_mode inside {MODE_RR, MODE_DEN}) ?
                            ((g == 0) ? r_colv[0] : 32'sd0) : r_colv[g];
            assign w_b[g] = r_vec;
            sds_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (r_ctl),
                .i_a    (w_a[g]),
                .i_b    (w_b[g]),
                .i_chain(w_ch[g]),
                .o_acc  (w_acc[g]),
                .o_chain(w_ch[g+1])
            );
        end
    endgenerate

    sds_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (r_rr),
        .i_den  (w_acc[0]),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    assign w_div_start = (r_state == S_DENW) && (r_cnt == 5'd3);
    assign w_s  = q_from_wide(64'(r_alpha) * 64'(r_r[w_j]));
    assign w_s2 = 64'(r_s) * 64'(r_s);

    assign o_stall = (r_state != S_IDLE);

    // operand feed: column j of the matrix for matrix-vector, else vectors
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < Dim; k++) begin
            case (r_mode) inside
                MODE_AX, MODE_AR: r_colv[k] <= r_mat[k][w_j];
                MODE_RR:          r_colv[k] <= r_r[w_j];
                default:          r_colv[k] <= r_p[w_j];
            endcase
        end
        case (r_mode)
            MODE_AX: r_vec <= r_x[w_j];
            default: r_vec <= r_r[w_j];
        endcase
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol   <= 63'd1;
            r_maxit <= 16'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TOL:   r_tol   <= i_cfg_data;
                CFG_MAXIT: r_maxit <= i_cfg_data[15:0];
                default:   ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        t_cell_ctl n_ctl;
        n_ctl = '0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ctl   <= '0;
            r_cnt   <= '0;
            r_mode  <= MODE_AX;
            r_s_vld <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            // step of element j is registered, then added to x and to s.s
            r_s     <= w_s;
            r_s_idx <= w_j;
            r_s_vld <= (r_state == S_UPD);
            if (r_s_vld) begin
                r_x[r_s_idx] <= sat32(64'(r_x[r_s_idx]) + 64'(r_s));
                r_ss         <= add_sat64(r_ss, w_s2);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        unique case (i_kind)
                            KIND_MAT: r_mat[i_row][i_col] <= i_value;
                            KIND_RHS: r_rhs[i_row] <= i_value;
                            KIND_SOL: r_x[i_row] <= i_value;
                            KIND_RUN: begin
                                r_iters <= '0;
                                r_state <= S_CHK;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CHK: begin
                    if (r_iters >= r_maxit) begin
                        r_status <= ST_LIMIT;
                        r_cnt    <= '0;
                        r_state  <= S_OUT;
                    end else begin
                        r_mode  <= MODE_AX;
                        r_cnt   <= '0;
                        n_ctl.clr = 1'b1;
                        r_state <= S_AX;
                    end
                end
                // stream columns: feed reg, product reg, then accumulate
                S_AX, S_RR, S_AR, S_DEN: begin
                    n_ctl.mac = (r_cnt >= 5'd1) && (r_cnt <= 5'(Dim));
                    if (r_cnt == 5'(Dim)) begin
                        r_cnt <= '0;
                        r_state <= (r_state == S_AX) ? S_AXW :
                                   (r_state == S_RR) ? S_RRW :
                                   (r_state == S_AR) ? S_ARW : S_DENW;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_AXW, S_ARW, S_RRW, S_DENW: begin
                    if (r_state == S_AXW && r_cnt == 5'd2) begin
                        r_cnt <= '0;
                        r_state <= S_RES;
                    end else if (r_state == S_ARW && r_cnt == 5'd2) begin
                        for (int k = 0; k < Dim; k++) r_p[k] <= q_from_wide(w_acc[k]);
                        r_mode <= MODE_DEN;
                        n_ctl.clr = 1'b1;
                        r_cnt <= '0;
                        r_state <= S_DEN;
                    end else if (r_state == S_RRW && r_cnt == 5'd2) begin
                        r_rr <= w_acc[0];
                        r_cnt <= '0;
                        if (w_acc[0] == 64'sd0) begin
                            r_status <= ST_CONV;
                            r_state  <= S_OUT;
                        end else begin
                            r_mode <= MODE_AR;
                            n_ctl.clr = 1'b1;
                            r_state <= S_AR;
                        end
                    end else if (r_state == S_DENW && r_cnt == 5'd3) begin
                        r_cnt <= '0;
                        if (w_acc[0] <= 64'sd0) begin
                            r_status <= ST_SING;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_RES: begin
                    for (int k = 0; k < Dim; k++)
                        r_r[k] <= sat32(64'(r_rhs[k]) - 64'(q_from_wide(w_acc[k])));
                    r_mode <= MODE_RR;
                    n_ctl.clr = 1'b1;
                    r_cnt <= '0;
                    r_state <= S_RR;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_alpha <= w_quot;
                        r_ss    <= '0;
                        r_cnt   <= '0;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (r_cnt == 5'(Dim - 1)) begin
                        r_iters <= r_iters + 16'd1;
                        r_state <= S_UPDW;
                    end
                    r_cnt <= r_cnt + 5'd1;
                end
                S_UPDW: begin
                    if (r_cnt == 5'(Dim)) begin
                        // last step still landing in r_ss
                        r_cnt <= r_cnt + 5'd1;
                    end else begin
                        r_cnt <= '0;
                        if (r_ss <= $signed({1'b0, r_tol})) begin
                            r_status <= ST_CONV;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_CHK;
                        end
                    end
                end
                S_OUT: begin
                    if (!o_valid || !i_stall) begin
                        if (o_valid && o_last) begin
                            o_valid <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            o_valid      <= 1'b1;
                            o_index      <= w_j;
                            o_solution   <= r_x[w_j];
                            o_iterations <= r_iters;
                            o_status     <= r_status;
                            o_last       <= (r_cnt == 5'(Dim - 1));
                            r_cnt        <= r_cnt + 5'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            r_ctl <= n_ctl;
        end
    end
endmodule
`default_nettype wire
